FILE: hdl/cbez_pkg.sv
`timescale 1ns / 1ps

package cbez_pkg;

    // Q1.16 parameter: fraction bits and the code for exactly one
    localparam int          T_FRAC      = 16;
    localparam logic [16:0] T_ONE       = 17'd65536;
    localparam logic [32:0] T_HALF_LSB  = 33'h0000_8000;

    // headroom kept on intermediate sums above the coordinate width
    localparam int GUARD_BITS = 6;

    // register stages inside each axis lane
    localparam int LANE_STAGES = 11;

    // per-axis compares taken at entry, plus the parameter end flags
    typedef struct packed {
        logic t_zero;
        logic t_one;
        logic eq01;
        logic eq23;
        logic eq20;
        logic eq31;
    } lane_flags_t;

endpackage

FILE: hdl/cbez_if.sv
`timescale 1ns / 1ps

interface cbez_in_if #(
    parameter int W = 32
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] p0_x;
    logic signed [W-1:0] p0_y;
    logic signed [W-1:0] p1_x;
    logic signed [W-1:0] p1_y;
    logic signed [W-1:0] p2_x;
    logic signed [W-1:0] p2_y;
    logic signed [W-1:0] p3_x;
    logic signed [W-1:0] p3_y;
    logic        [16:0]  param_t;

    modport source (
        output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, param_t,
        input  ready
    );
    modport sink (
        input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, param_t,
        output ready
    );
endinterface

interface cbez_out_if #(
    parameter int W = 32
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] pos_x;
    logic signed [W-1:0] pos_y;
    logic signed [W-1:0] tan_x;
    logic signed [W-1:0] tan_y;
    logic signed [W-1:0] curv_x;
    logic signed [W-1:0] curv_y;
    logic                saturated;

    modport source (
        output valid, pos_x, pos_y, tan_x, tan_y, curv_x, curv_y, saturated,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, tan_x, tan_y, curv_x, curv_y, saturated,
        output ready
    );
endinterface

FILE: hdl/cubic_bezier_point_tangent_eval.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   p0_x..p3_y (COORD_WIDTH signed), param_t (17 unsigned)
// out_ch    out  valid/ready   pos_*, tan_*, curv_* (COORD_WIDTH signed), saturated
//
// One request enters per cycle while in_ch.ready is high; at the accepting edge it lands
// in the first of 11 stages in each axis lane; three chained multiply-by-t steps take two
// stages each; the registered merge adds one more stage before the result is offered. Each
// stage advances when its successor is empty or moving, so bubbles collapse under an output
// stall and ready drops only when every stage holds a request.
// Reset clears the valid bits only.

module cubic_bezier_point_tangent_eval
    import cbez_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    cbez_in_if.sink    in_ch,
    cbez_out_if.source out_ch
);

    localparam int NS = LANE_STAGES;
    localparam int IW = COORD_WIDTH + GUARD_BITS;

    logic [NS:0]   rdy;
    logic [NS-1:0] vld_reg;
    logic          out_vld_reg;

    always_comb
    begin
        rdy[NS] = !out_vld_reg || out_ch.ready;
        for (int k = NS - 1; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    assign in_ch.ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_ch.valid;
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
            if (rdy[NS])
                out_vld_reg <= vld_reg[NS-1];
        end
    end

    logic signed [IW-1:0] pos_xw, tan_xw, curv_xw, repl_xw, full_xw;
    logic signed [IW-1:0] pos_yw, tan_yw, curv_yw, repl_yw, full_yw;
    lane_flags_t          flags_x, flags_y;

    cbez_lane #(.W(COORD_WIDTH)) u_lane_x (
        .clk     (clk),
        .en      (rdy[NS-1:0]),
        .p0      (in_ch.p0_x),
        .p1      (in_ch.p1_x),
        .p2      (in_ch.p2_x),
        .p3      (in_ch.p3_x),
        .param_t (in_ch.param_t),
        .pos     (pos_xw),
        .tan     (tan_xw),
        .curv    (curv_xw),
        .repl    (repl_xw),
        .full    (full_xw),
        .flags   (flags_x)
    );

    cbez_lane #(.W(COORD_WIDTH)) u_lane_y (
        .clk     (clk),
        .en      (rdy[NS-1:0]),
        .p0      (in_ch.p0_y),
        .p1      (in_ch.p1_y),
        .p2      (in_ch.p2_y),
        .p3      (in_ch.p3_y),
        .param_t (in_ch.param_t),
        .pos     (pos_yw),
        .tan     (tan_yw),
        .curv    (curv_yw),
        .repl    (repl_yw),
        .full    (full_yw),
        .flags   (flags_y)
    );

    logic signed [COORD_WIDTH-1:0] m_pos_x, m_pos_y, m_tan_x, m_tan_y, m_curv_x, m_curv_y;
    logic                          m_sat;

    cbez_merge #(.W(COORD_WIDTH)) u_merge (
        .pos_x_w   (pos_xw),
        .pos_y_w   (pos_yw),
        .tan_x_w   (tan_xw),
        .tan_y_w   (tan_yw),
        .curv_x_w  (curv_xw),
        .curv_y_w  (curv_yw),
        .repl_x    (repl_xw),
        .repl_y    (repl_yw),
        .full_x    (full_xw),
        .full_y    (full_yw),
        .flags_x   (flags_x),
        .flags_y   (flags_y),
        .pos_x     (m_pos_x),
        .pos_y     (m_pos_y),
        .tan_x     (m_tan_x),
        .tan_y     (m_tan_y),
        .curv_x    (m_curv_x),
        .curv_y    (m_curv_y),
        .saturated (m_sat)
    );

    logic signed [COORD_WIDTH-1:0] pos_x_reg, pos_y_reg, tan_x_reg, tan_y_reg;
    logic signed [COORD_WIDTH-1:0] curv_x_reg, curv_y_reg;
    logic                          sat_reg;

    // hold the result while the sink stalls
    always_ff @(posedge clk)
    begin
        if (rdy[NS])
        begin
            pos_x_reg  <= m_pos_x;
            pos_y_reg  <= m_pos_y;
            tan_x_reg  <= m_tan_x;
            tan_y_reg  <= m_tan_y;
            curv_x_reg <= m_curv_x;
            curv_y_reg <= m_curv_y;
            sat_reg    <= m_sat;
        end
    end

    assign out_ch.valid     = out_vld_reg;
    assign out_ch.pos_x     = pos_x_reg;
    assign out_ch.pos_y     = pos_y_reg;
    assign out_ch.tan_x     = tan_x_reg;
    assign out_ch.tan_y     = tan_y_reg;
    assign out_ch.curv_x    = curv_x_reg;
    assign out_ch.curv_y    = curv_y_reg;
    assign out_ch.saturated = sat_reg;

endmodule

FILE: hdl/cbez_lane.sv
`timescale 1ns / 1ps

module cbez_lane
    import cbez_pkg::*;
#(
    parameter int W = 32
) (
    input  logic                           clk,
    input  logic        [LANE_STAGES-1:0]  en,
    input  logic signed [W-1:0]            p0,
    input  logic signed [W-1:0]            p1,
    input  logic signed [W-1:0]            p2,
    input  logic signed [W-1:0]            p3,
    input  logic        [16:0]             param_t,
    output logic signed [W+GUARD_BITS-1:0] pos,
    output logic signed [W+GUARD_BITS-1:0] tan,
    output logic signed [W+GUARD_BITS-1:0] curv,
    output logic signed [W+GUARD_BITS-1:0] repl,
    output logic signed [W+GUARD_BITS-1:0] full,
    output lane_flags_t                    flags
);

    localparam int IW = W + GUARD_BITS;
    localparam int HW = IW - T_FRAC;
    localparam int PW = HW + 18;
    localparam int NS = LANE_STAGES;

    function automatic logic signed [IW-1:0] sx(input logic signed [W-1:0] v);
        sx = {{GUARD_BITS{v[W-1]}}, v};
    endfunction

    // integer part of x times t, exact
    function automatic logic signed [PW-1:0] hi_prod(input logic signed [IW-1:0] x,
                                                     input logic [16:0] t);
        hi_prod = $signed(x[IW-1:T_FRAC]) * $signed({1'b0, t});
    endfunction

    // fraction part of x times t, rounded half up onto the grid
    function automatic logic [16:0] lo_prod(input logic signed [IW-1:0] x,
                                            input logic [16:0] t);
        logic [32:0] m;
        m = 33'(x[T_FRAC-1:0]) * 33'(t) + T_HALF_LSB;
        lo_prod = m[32:16];
    endfunction

    function automatic logic signed [IW-1:0] join_prod(input logic signed [PW-1:0] ph,
                                                       input logic [16:0] pl);
        join_prod = $signed(ph[IW-1:0]) + $signed({{(IW-17){1'b0}}, pl});
    endfunction

    logic        [16:0]  t_sat;
    logic signed [IW-1:0] ep0, ep1, ep2, ep3;

    assign t_sat = (param_t > T_ONE) ? T_ONE : param_t;
    assign ep0   = sx(p0);
    assign ep1   = sx(p1);
    assign ep2   = sx(p2);
    assign ep3   = sx(p3);

    // values that ride along with the item, kept only as far as they are needed
    logic        [16:0]   t_q   [8];
    lane_flags_t          flg_q [NS];
    logic signed [IW-1:0] d_q   [10];
    logic signed [IW-1:0] c_q   [7];
    logic signed [IW-1:0] b_q   [1:3];
    logic signed [IW-1:0] r_q   [1:NS-1];
    logic signed [IW-1:0] g_q   [NS];
    logic signed [IW-1:0] cv_q  [4:NS-1];
    logic signed [IW-1:0] tn_q  [7:NS-1];

    logic signed [IW-1:0] e_reg;
    logic signed [IW-1:0] a_reg;
    logic signed [PW-1:0] pha_reg;
    logic        [16:0]   pla_reg;
    logic signed [IW-1:0] at_reg;
    logic signed [IW-1:0] u_reg;
    logic signed [IW-1:0] v_reg;
    logic signed [PW-1:0] phu_reg;
    logic        [16:0]   plu_reg;
    logic signed [PW-1:0] phv_reg;
    logic        [16:0]   plv_reg;
    logic signed [IW-1:0] ut_reg;
    logic signed [IW-1:0] vt_reg;
    logic signed [IW-1:0] u2_reg;
    logic signed [PW-1:0] ph2_reg;
    logic        [16:0]   pl2_reg;
    logic signed [IW-1:0] u2t_reg;
    logic signed [IW-1:0] pos_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
            begin
                flg_q[k] <= flg_q[k-1];
                g_q[k]   <= g_q[k-1];
            end
        end
        for (int k = 1; k < 8; k++)
        begin
            if (en[k])
                t_q[k] <= t_q[k-1];
        end
        for (int k = 1; k < 10; k++)
        begin
            if (en[k])
                d_q[k] <= d_q[k-1];
        end
        for (int k = 1; k < 7; k++)
        begin
            if (en[k])
                c_q[k] <= c_q[k-1];
        end
        for (int k = 2; k < 4; k++)
        begin
            if (en[k])
                b_q[k] <= b_q[k-1];
        end
        for (int k = 2; k < NS; k++)
        begin
            if (en[k])
                r_q[k] <= r_q[k-1];
        end
        for (int k = 5; k < NS; k++)
        begin
            if (en[k])
                cv_q[k] <= cv_q[k-1];
        end
        for (int k = 8; k < NS; k++)
        begin
            if (en[k])
                tn_q[k] <= tn_q[k-1];
        end

        // entry: control-point differences, clamped t and equality tests
        if (en[0])
        begin
            t_q[0]          <= t_sat;
            flg_q[0].t_zero <= (t_sat == 17'd0);
            flg_q[0].t_one  <= (t_sat == T_ONE);
            flg_q[0].eq01   <= (p0 == p1);
            flg_q[0].eq23   <= (p2 == p3);
            flg_q[0].eq20   <= (p2 == p0);
            flg_q[0].eq31   <= (p3 == p1);
            d_q[0]          <= ep0;
            c_q[0]          <= ep1 - ep0;
            e_reg           <= ep1 - ep2;
            g_q[0]          <= ep3 - ep0;
        end

        // power-basis A and B, and the fallback tangent for the end in use
        if (en[1])
        begin
            a_reg  <= g_q[0] + (e_reg <<< 1) + e_reg;
            b_q[1] <= -(e_reg + c_q[0]);
            r_q[1] <= flg_q[0].t_zero ? (c_q[0] - e_reg) : (g_q[0] - c_q[0]);
        end

        if (en[2])
        begin
            pha_reg <= hi_prod(a_reg, t_q[1]);
            pla_reg <= lo_prod(a_reg, t_q[1]);
        end

        if (en[3])
            at_reg <= join_prod(pha_reg, pla_reg);

        if (en[4])
        begin
            u_reg   <= at_reg + (b_q[3] <<< 1) + b_q[3];
            v_reg   <= at_reg + (b_q[3] <<< 1);
            cv_q[4] <= at_reg + b_q[3];
        end

        if (en[5])
        begin
            phu_reg <= hi_prod(u_reg, t_q[4]);
            plu_reg <= lo_prod(u_reg, t_q[4]);
            phv_reg <= hi_prod(v_reg, t_q[4]);
            plv_reg <= lo_prod(v_reg, t_q[4]);
        end

        if (en[6])
        begin
            ut_reg <= join_prod(phu_reg, plu_reg);
            vt_reg <= join_prod(phv_reg, plv_reg);
        end

        if (en[7])
        begin
            u2_reg  <= ut_reg + (c_q[6] <<< 1) + c_q[6];
            tn_q[7] <= vt_reg + c_q[6];
        end

        if (en[8])
        begin
            ph2_reg <= hi_prod(u2_reg, t_q[7]);
            pl2_reg <= lo_prod(u2_reg, t_q[7]);
        end

        if (en[9])
            u2t_reg <= join_prod(ph2_reg, pl2_reg);

        if (en[10])
            pos_reg <= u2t_reg + d_q[9];
    end

    assign pos   = pos_reg;
    assign tan   = tn_q[NS-1];
    assign curv  = cv_q[NS-1];
    assign repl  = r_q[NS-1];
    assign full  = g_q[NS-1];
    assign flags = flg_q[NS-1];

endmodule

FILE: hdl/cbez_merge.sv
`timescale 1ns / 1ps

module cbez_merge
    import cbez_pkg::*;
#(
    parameter int W = 32
) (
    input  logic signed [W+GUARD_BITS-1:0] pos_x_w,
    input  logic signed [W+GUARD_BITS-1:0] pos_y_w,
    input  logic signed [W+GUARD_BITS-1:0] tan_x_w,
    input  logic signed [W+GUARD_BITS-1:0] tan_y_w,
    input  logic signed [W+GUARD_BITS-1:0] curv_x_w,
    input  logic signed [W+GUARD_BITS-1:0] curv_y_w,
    input  logic signed [W+GUARD_BITS-1:0] repl_x,
    input  logic signed [W+GUARD_BITS-1:0] repl_y,
    input  logic signed [W+GUARD_BITS-1:0] full_x,
    input  logic signed [W+GUARD_BITS-1:0] full_y,
    input  lane_flags_t                    flags_x,
    input  lane_flags_t                    flags_y,
    output logic signed [W-1:0]            pos_x,
    output logic signed [W-1:0]            pos_y,
    output logic signed [W-1:0]            tan_x,
    output logic signed [W-1:0]            tan_y,
    output logic signed [W-1:0]            curv_x,
    output logic signed [W-1:0]            curv_y,
    output logic                           saturated
);

    localparam int IW = W + GUARD_BITS;

    // clip flag in the top bit, clamped value below it
    function automatic logic [W:0] clamp(input logic signed [IW-1:0] v);
        logic fits;
        fits = (&v[IW-1:W-1]) || !(|v[IW-1:W-1]);
        if (fits)
            clamp = {1'b0, v[W-1:0]};
        else if (v[IW-1])
            clamp = {1'b1, 1'b1, {(W-1){1'b0}}};
        else
            clamp = {1'b1, 1'b0, {(W-1){1'b1}}};
    endfunction

    logic                 start_deg;
    logic                 end_deg;
    logic                 repl_zero;
    logic signed [IW-1:0] tx;
    logic signed [IW-1:0] ty;
    logic [W:0]           s_px, s_py, s_tx, s_ty, s_cx, s_cy;

    assign start_deg = flags_x.t_zero && flags_x.eq01 && flags_y.eq01;
    assign end_deg   = flags_x.t_one && flags_x.eq23 && flags_y.eq23;
    assign repl_zero = flags_x.t_zero ? (flags_x.eq20 && flags_y.eq20)
                                      : (flags_x.eq31 && flags_y.eq31);

    // a collapsed end handle borrows the chord to the next distinct point
    always_comb
    begin
        if (start_deg || end_deg)
        begin
            tx = repl_zero ? full_x : repl_x;
            ty = repl_zero ? full_y : repl_y;
        end
        else
        begin
            tx = tan_x_w;
            ty = tan_y_w;
        end
    end

    assign s_px = clamp(pos_x_w);
    assign s_py = clamp(pos_y_w);
    assign s_tx = clamp(tx);
    assign s_ty = clamp(ty);
    assign s_cx = clamp(curv_x_w);
    assign s_cy = clamp(curv_y_w);

    assign pos_x     = s_px[W-1:0];
    assign pos_y     = s_py[W-1:0];
    assign tan_x     = s_tx[W-1:0];
    assign tan_y     = s_ty[W-1:0];
    assign curv_x    = s_cx[W-1:0];
    assign curv_y    = s_cy[W-1:0];
    assign saturated = s_px[W] | s_py[W] | s_tx[W] | s_ty[W] | s_cx[W] | s_cy[W];

endmodule

FILE: tb/sv/cubic_bezier_point_tangent_eval_test.sv
`timescale 1ns / 1ps

module cubic_bezier_point_tangent_eval_test;
    import cbez_pkg::*;

    localparam int     W            = 32;
    localparam int     RANDOM_COUNT = 700;
    localparam int     PAUSE_AT     = 350;
    localparam int     DRAIN_CYCLES = 24;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam longint CMAX         = 64'sd2147483647;
    localparam longint CMIN         = -CMAX - 1;
    localparam logic signed [W-1:0] SMAX = 32'sh7FFF_FFFF;
    localparam logic signed [W-1:0] SMIN = 32'sh8000_0000;
    localparam logic signed [W-1:0] ONE  = 32'sh0001_0000;

    typedef struct {
        logic signed [W-1:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
        logic        [16:0]  param_t;
    } curve_req_t;

    typedef struct {
        logic signed [W-1:0] pos_x, pos_y, tan_x, tan_y, curv_x, curv_y;
        logic                saturated;
    } curve_res_t;

    typedef struct {
        curve_req_t req;
        bit         typed;
        curve_res_t want;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n;

    cbez_in_if  #(.W(W)) in_ch ();
    cbez_out_if #(.W(W)) out_ch ();

    cubic_bezier_point_tangent_eval #(
        .COORD_WIDTH(W)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    curve_res_t curve_results_q[$];
    table_row_t stim_table[$];
    int         errors;
    int         results_seen;
    int         clipped_seen;
    int         requests_sent;

    // multiply by t in Q1.16, round half up
    function automatic longint scale_t(longint x, longint t);
        return (x * t + 64'sh8000) >>> T_FRAC;
    endfunction

    function automatic bit out_of_range(longint v);
        return (v > CMAX) || (v < CMIN);
    endfunction

    function automatic logic signed [W-1:0] clamp(longint v);
        if (v > CMAX)
        begin
            return SMAX;
        end
        if (v < CMIN)
        begin
            return SMIN;
        end
        return v[W-1:0];
    endfunction

    function automatic curve_res_t eval_curve(curve_req_t r);
        longint     px[4];
        longint     py[4];
        longint     p[4];
        longint     t, a, b, c, pos, crv;
        longint     tng[2];
        bit         start_flat, end_flat, hit;
        int         k, j;
        curve_res_t res;

        px[0] = r.p0_x; px[1] = r.p1_x; px[2] = r.p2_x; px[3] = r.p3_x;
        py[0] = r.p0_y; py[1] = r.p1_y; py[2] = r.p2_y; py[3] = r.p3_y;
        t = r.param_t;
        if (t > T_ONE)
        begin
            t = T_ONE;
        end
        hit = 1'b0;
        for (k = 0; k < 2; k++)
        begin
            for (j = 0; j < 4; j++)
            begin
                p[j] = (k == 0) ? px[j] : py[j];
            end
            a      = p[3] + 3 * (p[1] - p[2]) - p[0];
            b      = p[2] - 2 * p[1] + p[0];
            c      = p[1] - p[0];
            pos    = scale_t(scale_t(scale_t(a, t) + 3 * b, t) + 3 * c, t) + p[0];
            tng[k] = scale_t(scale_t(a, t) + 2 * b, t) + c;
            crv    = scale_t(a, t) + b;
            hit    = hit | out_of_range(pos) | out_of_range(crv);
            if (k == 0)
            begin
                res.pos_x  = clamp(pos);
                res.curv_x = clamp(crv);
            end
            else
            begin
                res.pos_y  = clamp(pos);
                res.curv_y = clamp(crv);
            end
        end

        // flat ends: derivative vanishes, use the chord to the next distinct point
        start_flat = (t == 0) && (px[0] == px[1]) && (py[0] == py[1]);
        end_flat   = (t == T_ONE) && (px[2] == px[3]) && (py[2] == py[3]);
        if (start_flat || end_flat)
        begin
            if (t == 0)
            begin
                tng[0] = px[2] - px[0];
                tng[1] = py[2] - py[0];
            end
            else
            begin
                tng[0] = px[3] - px[1];
                tng[1] = py[3] - py[1];
            end
            if (tng[0] == 0 && tng[1] == 0)
            begin
                tng[0] = px[3] - px[0];
                tng[1] = py[3] - py[0];
            end
        end
        hit           = hit | out_of_range(tng[0]) | out_of_range(tng[1]);
        res.tan_x     = clamp(tng[0]);
        res.tan_y     = clamp(tng[1]);
        res.saturated = hit;
        return res;
    endfunction

    function automatic curve_req_t mk_req(
        logic signed [W-1:0] x0, y0, x1, y1, x2, y2, x3, y3,
        logic        [16:0]  t
    );
        curve_req_t r;
        r.p0_x = x0; r.p0_y = y0; r.p1_x = x1; r.p1_y = y1;
        r.p2_x = x2; r.p2_y = y2; r.p3_x = x3; r.p3_y = y3;
        r.param_t = t;
        return r;
    endfunction

    function automatic curve_res_t mk_res(
        logic signed [W-1:0] px, py, tx, ty, cx, cy,
        logic                sat
    );
        curve_res_t r;
        r.pos_x = px; r.pos_y = py; r.tan_x = tx; r.tan_y = ty;
        r.curv_x = cx; r.curv_y = cy; r.saturated = sat;
        return r;
    endfunction

    task automatic add_row(curve_req_t req, bit typed, curve_res_t want);
        table_row_t row;
        row.req   = req;
        row.typed = typed;
        row.want  = want;
        stim_table.push_back(row);
    endtask

    function automatic logic signed [W-1:0] pick_coord(int style);
        logic signed [W-1:0] v;
        case (style)
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh2_0000;
            default:
            begin
                case ($urandom_range(0, 4))
                    0: v = SMAX;
                    1: v = SMIN;
                    2: v = '0;
                    3: v = $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [16:0] pick_param();
        logic [16:0] t;
        case ($urandom_range(0, 9))
            0: t = '0;
            1: t = T_ONE;
            2: t = 17'($urandom_range(int'(T_ONE) + 1, 17'h1FFFF));
            3: t = $urandom_range(0, 1) ? 17'd1 : 17'hFFFF;
            4: t = 17'($urandom_range(0, 17'h1FFFF));
            default: t = 17'($urandom_range(0, int'(T_ONE) - 1));
        endcase
        return t;
    endfunction

    function automatic curve_req_t random_curve();
        curve_req_t r;
        int         kind;
        int         style;
        kind  = $urandom_range(0, 9);
        style = (kind <= 2) ? 0 : ((kind == 5 || kind == 6) ? 2 : 1);
        r = mk_req(pick_coord(style), pick_coord(style), pick_coord(style),
                   pick_coord(style), pick_coord(style), pick_coord(style),
                   pick_coord(style), pick_coord(style), pick_param());
        if (kind == 7 || kind == 8)
        begin
            // steer into the flat-end tangent rules
            if ($urandom_range(0, 1))
            begin
                r.param_t = '0;
                r.p1_x = r.p0_x; r.p1_y = r.p0_y;
                if ($urandom_range(0, 2) == 0)
                begin
                    r.p2_x = r.p0_x; r.p2_y = r.p0_y;
                    if ($urandom_range(0, 1))
                    begin
                        r.p3_x = r.p0_x; r.p3_y = r.p0_y;
                    end
                end
            end
            else
            begin
                r.param_t = ($urandom_range(0, 2) == 0)
                          ? 17'($urandom_range(int'(T_ONE) + 1, 17'h1FFFF)) : T_ONE;
                r.p3_x = r.p2_x; r.p3_y = r.p2_y;
                if ($urandom_range(0, 2) == 0)
                begin
                    r.p1_x = r.p3_x; r.p1_y = r.p3_y;
                    if ($urandom_range(0, 1))
                    begin
                        r.p0_x = r.p3_x; r.p0_y = r.p3_y;
                    end
                end
            end
        end
        else if (kind == 9)
        begin
            r.p1_x = r.p0_x; r.p1_y = r.p0_y;
            r.p2_x = r.p0_x; r.p2_y = r.p0_y;
            r.p3_x = r.p0_x; r.p3_y = r.p0_y;
        end
        return r;
    endfunction

    task automatic send_request(curve_req_t r, bit typed, curve_res_t want);
        in_ch.valid   <= 1'b1;
        in_ch.p0_x    <= r.p0_x;
        in_ch.p0_y    <= r.p0_y;
        in_ch.p1_x    <= r.p1_x;
        in_ch.p1_y    <= r.p1_y;
        in_ch.p2_x    <= r.p2_x;
        in_ch.p2_y    <= r.p2_y;
        in_ch.p3_x    <= r.p3_x;
        in_ch.p3_y    <= r.p3_y;
        in_ch.param_t <= r.param_t;
        do
        begin
            @(posedge clk);
        end
        while (in_ch.ready !== 1'b1);
        curve_results_q.push_back(typed ? want : eval_curve(r));
        requests_sent++;
    endtask

    // drop valid for a random gap, possibly none, at the start of each burst
    task automatic burst_gap(inout int burst_left);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic check_field(string name, logic signed [W-1:0] want,
                               logic signed [W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        curve_res_t want;
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            results_seen++;
            if (out_ch.saturated === 1'b1)
            begin
                clipped_seen++;
            end
            if (curve_results_q.size() == 0)
            begin
                $display("%0t: result with none expected: expected nothing, actual pos %h,%h",
                         $time, out_ch.pos_x, out_ch.pos_y);
                errors++;
            end
            else
            begin
                want = curve_results_q.pop_front();
                check_field("pos_x", want.pos_x, out_ch.pos_x);
                check_field("pos_y", want.pos_y, out_ch.pos_y);
                check_field("tan_x", want.tan_x, out_ch.tan_x);
                check_field("tan_y", want.tan_y, out_ch.tan_y);
                check_field("curv_x", want.curv_x, out_ch.curv_x);
                check_field("curv_y", want.curv_y, out_ch.curv_y);
                check_field("saturated", W'(want.saturated), W'(out_ch.saturated));
            end
        end
    end

    // output stalls: switch at random between stall styles
    initial
    begin : result_stall
        int mode;
        int len;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 4);
            len  = $urandom_range(20, 200);
            repeat (len)
            begin
                case (mode)
                    0, 1: out_ch.ready <= 1'b1;
                    2:    out_ch.ready <= 1'($urandom_range(0, 1));
                    3:    out_ch.ready <= ($urandom_range(0, 9) != 0);
                    default: out_ch.ready <= ($urandom_range(0, 15) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: timeout, %0d results still outstanding", $time,
                 curve_results_q.size());
        $display("** cubic_bezier_point_tangent_eval: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        curve_res_t none;
        int         burst_left;
        int         i;

        errors        = 0;
        results_seen  = 0;
        clipped_seen  = 0;
        requests_sent = 0;
        burst_left    = 0;
        none          = mk_res(0, 0, 0, 0, 0, 0, 1'b0);

        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.p0_x    <= '0;
        in_ch.p0_y    <= '0;
        in_ch.p1_x    <= '0;
        in_ch.p1_y    <= '0;
        in_ch.p2_x    <= '0;
        in_ch.p2_y    <= '0;
        in_ch.p3_x    <= '0;
        in_ch.p3_y    <= '0;
        in_ch.param_t <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, none);
        add_row(mk_req(ONE, -2 * ONE, ONE, -2 * ONE, ONE, -2 * ONE, ONE, -2 * ONE, 17'h8000),
                1, mk_res(ONE, -2 * ONE, 0, 0, 0, 0, 1'b0));
        // unit square corners at both ends and with t above one
        add_row(mk_req(0, 0, ONE, 0, ONE, ONE, 0, ONE, 0),
                1, mk_res(0, 0, ONE, 0, -ONE, ONE, 1'b0));
        add_row(mk_req(0, 0, ONE, 0, ONE, ONE, 0, ONE, T_ONE),
                1, mk_res(0, ONE, -ONE, 0, -ONE, -ONE, 1'b0));
        add_row(mk_req(0, 0, ONE, 0, ONE, ONE, 0, ONE, 17'h1FFFF),
                1, mk_res(0, ONE, -ONE, 0, -ONE, -ONE, 1'b0));
        // flat start, then flat start with p2 on p0 as well
        add_row(mk_req(ONE, ONE, ONE, ONE, 3 * ONE, ONE, 0, 0, 0),
                1, mk_res(ONE, ONE, 2 * ONE, 0, 2 * ONE, 0, 1'b0));
        add_row(mk_req(5, 7, 5, 7, 5, 7, ONE + 5, 7, 0),
                1, mk_res(5, 7, ONE, 0, 0, 0, 1'b0));
        // flat end at t one and above one, then flat end with p1 on p3 as well
        add_row(mk_req(4 * ONE, 0, ONE, -ONE, 0, 0, 0, 0, T_ONE),
                1, mk_res(0, 0, -ONE, ONE, ONE, -ONE, 1'b0));
        add_row(mk_req(4 * ONE, 0, ONE, -ONE, 0, 0, 0, 0, 17'h10001),
                1, mk_res(0, 0, -ONE, ONE, ONE, -ONE, 1'b0));
        add_row(mk_req(ONE + 3, 3, 3, 3, 3, 3, 3, 3, T_ONE),
                1, mk_res(3, 3, -ONE, 0, 0, 0, 1'b0));
        add_row(mk_req(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, 17'h8000),
                1, mk_res(SMAX, SMAX, 0, 0, 0, 0, 1'b0));
        add_row(mk_req(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 0),
                1, mk_res(SMIN, SMIN, 0, 0, 0, 0, 1'b0));
        // clipping of the tangent and curvature term
        add_row(mk_req(SMIN, 0, SMAX, 0, SMAX, 0, 0, 0, 0),
                1, mk_res(SMIN, 0, SMAX, 0, SMIN, 0, 1'b1));
        add_row(mk_req(SMIN, 0, SMIN, 0, SMAX, 0, 0, 0, 0),
                1, mk_res(SMIN, 0, SMAX, 0, SMAX, 0, 1'b1));
        add_row(mk_req(SMIN, SMAX, SMAX, SMIN, SMIN, SMAX, SMAX, SMIN, 17'h8000), 0, none);
        add_row(mk_req(SMIN, SMAX, SMAX, SMIN, SMIN, SMAX, SMAX, SMIN, 17'h0001), 0, none);
        add_row(mk_req(SMIN, SMAX, SMAX, SMIN, SMIN, SMAX, SMAX, SMIN, 17'hFFFF), 0, none);
        add_row(mk_req(SMAX, SMIN, SMIN, SMAX, SMAX, SMIN, SMIN, SMAX, T_ONE), 0, none);
        // rounding ties on odd coordinates
        add_row(mk_req(0, 0, 1, -1, 0, 0, 1, -1, 17'h8000), 0, none);
        add_row(mk_req(3, -3, -5, 7, 11, -13, -17, 19, 17'h8000), 0, none);
        add_row(mk_req(32'sh12345, -32'sh6789A, 32'sh2468A, 32'sh13579, -32'sh0ACE1,
                       32'sh5F5F5, 32'sh7007, -32'sh1111, 17'h4000), 0, none);
        // near misses of the flat-end rules
        add_row(mk_req(ONE, ONE, ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0), 0, none);
        add_row(mk_req(ONE, 0, 2 * ONE, ONE, 5, 5, 5, 5, 0), 0, none);
        add_row(mk_req(ONE, ONE, ONE, ONE, 3 * ONE, -ONE, 0, 7, T_ONE), 0, none);

        foreach (stim_table[n])
        begin
            burst_gap(burst_left);
            send_request(stim_table[n].req, stim_table[n].typed, stim_table[n].want);
        end

        for (i = 0; i < RANDOM_COUNT; i++)
        begin
            if (i == PAUSE_AT)
            begin
                // hold off until the pipeline has fully drained
                in_ch.valid <= 1'b0;
                while (curve_results_q.size() != 0)
                begin
                    @(posedge clk);
                end
                burst_left = 0;
            end
            burst_gap(burst_left);
            send_request(random_curve(), 0, none);
        end
        in_ch.valid <= 1'b0;

        while (curve_results_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (curve_results_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, curve_results_q.size());
            errors++;
        end

        $display("Sent %0d curve requests (%0d from the directed table), checked %0d results,",
                 requests_sent, stim_table.size(), results_seen);
        $display("%0d of them clipped; %0d mismatches.", clipped_seen, errors);
        if (errors == 0)
        begin
            $display("** cubic_bezier_point_tangent_eval: PASSED **");
        end
        else
        begin
            $display("** cubic_bezier_point_tangent_eval: FAILED **");
        end
        $finish;
    end

endmodule

FILE: cubic_bezier_point_tangent_eval.f
hdl/cbez_pkg.sv
hdl/cbez_if.sv
hdl/cbez_lane.sv
hdl/cbez_merge.sv
hdl/cubic_bezier_point_tangent_eval.sv
tb/sv/cubic_bezier_point_tangent_eval_test.sv
